// ----- rtl/core/assert_macros.svh -----
// assertion macros used by the ranger top level
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only out of reset
`define ASSERT_CLKD(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// checked on every edge, reset included
`define ASSERT_CLKA(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/core/uer_pkg.sv -----
// types, constants and widths for the echo ranger
// no dependencies
`timescale 1ns / 1ps

package uer_pkg;

    localparam int ROUNDS    = 5;
    localparam int COUNT_W   = 20;
    localparam int TRIG_W    = 10;
    localparam int GAP_W     = 20;
    localparam int SCALE_W   = 16;
    localparam int DIST_W    = 19;
    localparam int SUM_W     = 22;
    localparam int ROUND_W   = 3;
    localparam int ZONE_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 20;

    localparam int TICK_W    = (COUNT_W > GAP_W) ? COUNT_W : GAP_W;
    localparam int PROD_W    = COUNT_W + SCALE_W;
    localparam int CMP_W     = (COUNT_W > DIST_W) ? COUNT_W : DIST_W;

    // floor(x / ROUNDS) as (x * ceil(2^k / ROUNDS)) >> k, exact for x < 2^SUM_W
    localparam int DIV_SHIFT = SUM_W + 3;
    localparam int RECIP_W   = SUM_W + 4;
    localparam int AVG_PW    = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] DIV_RECIP =
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(ROUNDS) - 64'd1) / 64'(ROUNDS));

    localparam logic [DIST_W-1:0]  DIST_MAX   = '1;
    localparam logic [TICK_W-1:0]  COUNT_MAX  = TICK_W'((64'd1 << COUNT_W) - 64'd1);
    localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(ROUNDS - 1);

    localparam logic [ZONE_W-1:0] ZONE_NEAR = 2'd0;
    localparam logic [ZONE_W-1:0] ZONE_MID  = 2'd1;
    localparam logic [ZONE_W-1:0] ZONE_FAR  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_TICKS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_TICKS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_FACTOR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_LIMIT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FAR_LIMIT     = 3'd4;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_TRIG = 3'd1,
        PH_WAIT = 3'd2,
        PH_MEAS = 3'd3,
        PH_GAP  = 3'd4
    } t_phase;

    typedef struct packed {
        logic [TRIG_W-1:0]  trigger_ticks;
        logic [GAP_W-1:0]   gap_ticks;
        logic [SCALE_W-1:0] scale_factor;
        logic [DIST_W-1:0]  near_limit;
        logic [DIST_W-1:0]  far_limit;
    } t_cfg;

    typedef struct packed {
        logic              trigger;
        logic              busy;
        logic              done;
        logic [DIST_W-1:0] distance;
        logic [ZONE_W-1:0] zone;
    } t_result;

endpackage

// ----- rtl/core/uer_ctrl.sv -----
// measurement sequencer: trigger, echo timing, scaling, averaging and zoning
// depends on uer_pkg
`timescale 1ns / 1ps

module uer_ctrl import uer_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  logic    i_start_req,
    input  logic    i_echo,
    input  t_cfg    i_cfg,
    output t_result o_res
);

    t_phase              r_phase, n_phase;
    logic [TICK_W-1:0]   r_tick, n_tick;
    logic [ROUND_W-1:0]  r_round, n_round;
    logic [SUM_W-1:0]    r_sum, n_sum;
    logic [DIST_W-1:0]   r_dist, n_dist;
    logic [ZONE_W-1:0]   r_zone, n_zone;
    logic                n_done;

    logic [PROD_W-1:0]   w_prod;
    logic [COUNT_W-1:0]  w_scaled;
    logic [DIST_W-1:0]   w_meas_dist;
    logic [AVG_PW-1:0]   w_avg_prod;
    logic [SUM_W-1:0]    w_avg;
    logic [DIST_W-1:0]   w_avg_sat;
    logic [ZONE_W-1:0]   w_avg_zone;

    // echo ticks to hundredths of cm
    assign w_prod      = PROD_W'(r_tick[COUNT_W-1:0]) * PROD_W'(i_cfg.scale_factor);
    assign w_scaled    = w_prod[PROD_W-1:SCALE_W];
    assign w_meas_dist = (CMP_W'(w_scaled) > CMP_W'(DIST_MAX)) ? DIST_MAX
                                                                : DIST_W'(w_scaled);

    // average over the burst
    assign w_avg_prod = AVG_PW'(r_sum) * AVG_PW'(DIV_RECIP);
    assign w_avg      = w_avg_prod[DIV_SHIFT+SUM_W-1:DIV_SHIFT];
    assign w_avg_sat  = (w_avg > SUM_W'(DIST_MAX)) ? DIST_MAX : w_avg[DIST_W-1:0];

    always_comb begin
        if (w_avg_sat > i_cfg.far_limit) begin
            w_avg_zone = ZONE_FAR;
        end else if (w_avg_sat > i_cfg.near_limit) begin
            w_avg_zone = ZONE_MID;
        end else begin
            w_avg_zone = ZONE_NEAR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_tick  <= '0;
            r_round <= '0;
            r_sum   <= '0;
            r_dist  <= '0;
            r_zone  <= ZONE_NEAR;
        end else begin
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_round <= n_round;
            r_sum   <= n_sum;
            r_dist  <= n_dist;
            r_zone  <= n_zone;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_tick  = r_tick;
        n_round = r_round;
        n_sum   = r_sum;
        n_dist  = r_dist;
        n_zone  = r_zone;
        n_done  = 1'b0;
        if (i_step) begin
            case (r_phase)
                PH_IDLE: begin
                    if (i_start_req) begin
                        n_phase = PH_TRIG;
                        n_tick  = TICK_W'(1);
                        n_round = '0;
                        n_sum   = '0;
                    end
                end
                PH_TRIG: begin
                    if (r_tick >= TICK_W'(i_cfg.trigger_ticks)) begin
                        n_phase = PH_WAIT;
                        n_tick  = '0;
                    end else begin
                        n_tick = r_tick + TICK_W'(1);
                    end
                end
                PH_WAIT: begin
                    if (i_echo) begin
                        n_phase = PH_MEAS;
                        n_tick  = TICK_W'(1);
                    end
                end
                PH_MEAS: begin
                    if (i_echo) begin
                        if (r_tick < COUNT_MAX) begin
                            n_tick = r_tick + TICK_W'(1);
                        end
                    end else begin
                        n_sum   = r_sum + SUM_W'(w_meas_dist);
                        n_phase = PH_GAP;
                        n_tick  = '0;
                    end
                end
                PH_GAP: begin
                    if (r_tick >= TICK_W'(i_cfg.gap_ticks)) begin
                        if (r_round >= LAST_ROUND) begin
                            n_dist  = w_avg_sat;
                            n_zone  = w_avg_zone;
                            n_done  = 1'b1;
                            n_phase = PH_IDLE;
                            n_tick  = '0;
                            n_round = '0;
                        end else begin
                            n_round = r_round + ROUND_W'(1);
                            n_phase = PH_TRIG;
                            n_tick  = TICK_W'(1);
                        end
                    end else begin
                        n_tick = r_tick + TICK_W'(1);
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                    n_tick  = '0;
                end
            endcase
        end
    end

    assign o_res.trigger  = (n_phase == PH_TRIG);
    assign o_res.busy     = (n_phase != PH_IDLE);
    assign o_res.done     = n_done;
    assign o_res.distance = n_dist;
    assign o_res.zone     = n_zone;

endmodule

// ----- rtl/core/ultrasonic_echo_ranger_unit.sv -----
// ultrasonic echo ranger top level: config registers, sequencer, result register
// result: registered, appearing in the cycle after its tick is transferred in
// throughput: one tick per cycle, held only while the single result register is full and stalled
// reset: sequencer idle, sums and last distance cleared, config at defaults
// depends on uer_pkg, uer_ctrl and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ultrasonic_echo_ranger_unit import uer_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_start_req,
    input  logic                 i_echo,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_trigger,
    output logic                 o_busy_res,
    output logic                 o_done_res,
    output logic [DIST_W-1:0]    o_distance,
    output logic [ZONE_W-1:0]    o_zone,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    t_cfg    r_cfg;
    t_result w_res;
    t_result r_res;
    logic    r_out_valid;
    logic    w_accept;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_out_valid & i_out_stall;
    assign w_accept    = i_in_valid & ~o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trigger_ticks <= TRIG_W'(40);
            r_cfg.gap_ticks     <= GAP_W'(400000);
            r_cfg.scale_factor  <= SCALE_W'(27853);
            r_cfg.near_limit    <= DIST_W'(10000);
            r_cfg.far_limit     <= DIST_W'(20000);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_TRIGGER_TICKS: r_cfg.trigger_ticks <= i_cfg_data[TRIG_W-1:0];
                CFG_GAP_TICKS:     r_cfg.gap_ticks     <= i_cfg_data[GAP_W-1:0];
                CFG_SCALE_FACTOR:  r_cfg.scale_factor  <= i_cfg_data[SCALE_W-1:0];
                CFG_NEAR_LIMIT:    r_cfg.near_limit    <= i_cfg_data[DIST_W-1:0];
                CFG_FAR_LIMIT:     r_cfg.far_limit     <= i_cfg_data[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    uer_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_accept),
        .i_start_req (i_start_req),
        .i_echo      (i_echo),
        .i_cfg       (r_cfg),
        .o_res       (w_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_res <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_trigger   = r_res.trigger;
    assign o_busy_res  = r_res.busy;
    assign o_done_res  = r_res.done;
    assign o_distance  = r_res.distance;
    assign o_zone      = r_res.zone;

    `ASSERT_CLKD(a_trig_busy, i_clk, i_rst_n, (o_out_valid && o_trigger) |-> o_busy_res, "trigger outside a burst")
    `ASSERT_CLKD(a_done_idle, i_clk, i_rst_n, (o_out_valid && o_done_res) |-> !o_busy_res, "done while still busy")
    `ASSERT_CLKD(a_done_once, i_clk, i_rst_n, (w_accept && w_res.done) |=> !(w_accept && w_res.done), "two done transfers in a row")
    `ASSERT_CLKA(a_stall_held, i_clk, o_in_stall |-> o_out_valid, "input stalled with empty result register")

endmodule

// ----- bench/tb_ultrasonic_echo_ranger_unit.sv -----
// testbench for the ultrasonic echo ranger: directed and random timer ticks, every output
// transfer checked field by field against a cycle model of the burst sequencer kept here
// depends on uer_pkg and ultrasonic_echo_ranger_unit
`timescale 1ns / 1ps

module tb_ultrasonic_echo_ranger_unit;
    import uer_pkg::*;

    typedef struct packed {
        logic start_req;
        logic echo;
    } t_tick;

    localparam int QUIET_LIMIT = 2000;
    localparam int PHASE_TICKS = 80;
    localparam int SETTING_RUNS = 10;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic                 i_start_req;
    logic                 i_echo;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic                 o_trigger;
    logic                 o_busy_res;
    logic                 o_done_res;
    logic [DIST_W-1:0]    o_distance;
    logic [ZONE_W-1:0]    o_zone;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    // sequencer model
    t_cfg               ranger_cfg;
    t_phase             seq_phase;
    logic [TICK_W-1:0]  tick_cnt;
    logic [ROUND_W-1:0] round_idx;
    logic [SUM_W-1:0]   dist_sum;
    logic [DIST_W-1:0]  last_dist;
    logic [ZONE_W-1:0]  last_zone;

    t_tick   echo_ticks[$];
    t_result ranger_readings[$];
    bit      tick_live;

    int mismatches;
    int readings_checked;
    int bursts_averaged;
    int ticks_generated;
    int settings_applied;
    int zone_hits[3];
    int sender_gap_pct;
    int recv_stall_pct;
    int quiet_cycles;

    ultrasonic_echo_ranger_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_start_req (i_start_req),
        .i_echo      (i_echo),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_trigger   (o_trigger),
        .o_busy_res  (o_busy_res),
        .o_done_res  (o_done_res),
        .o_distance  (o_distance),
        .o_zone      (o_zone),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic ranger_reset();
        ranger_cfg.trigger_ticks = TRIG_W'(40);
        ranger_cfg.gap_ticks     = GAP_W'(400000);
        ranger_cfg.scale_factor  = SCALE_W'(27853);
        ranger_cfg.near_limit    = DIST_W'(10000);
        ranger_cfg.far_limit     = DIST_W'(20000);
        seq_phase = PH_IDLE;
        tick_cnt  = '0;
        round_idx = '0;
        dist_sum  = '0;
        last_dist = '0;
        last_zone = ZONE_NEAR;
    endtask

    task automatic ranger_step(input logic start_req, input logic echo);
        t_result           reading;
        logic [PROD_W-1:0] scaled;
        logic [SUM_W-1:0]  avg;
        reading.done = 1'b0;
        case (seq_phase)
            PH_IDLE: begin
                if (start_req) begin
                    seq_phase = PH_TRIG;
                    tick_cnt  = TICK_W'(1);
                    round_idx = '0;
                    dist_sum  = '0;
                end
            end
            PH_TRIG: begin
                if (tick_cnt >= TICK_W'(ranger_cfg.trigger_ticks)) begin
                    seq_phase = PH_WAIT;
                    tick_cnt  = '0;
                end else begin
                    tick_cnt = tick_cnt + TICK_W'(1);
                end
            end
            PH_WAIT: begin
                if (echo) begin
                    seq_phase = PH_MEAS;
                    tick_cnt  = TICK_W'(1);
                end
            end
            PH_MEAS: begin
                if (echo) begin
                    if (tick_cnt < COUNT_MAX) tick_cnt = tick_cnt + TICK_W'(1);
                end else begin
                    scaled = (PROD_W'(tick_cnt) * PROD_W'(ranger_cfg.scale_factor)) >> SCALE_W;
                    if (scaled > PROD_W'(DIST_MAX)) scaled = PROD_W'(DIST_MAX);
                    dist_sum  = dist_sum + SUM_W'(scaled);
                    seq_phase = PH_GAP;
                    tick_cnt  = '0;
                end
            end
            PH_GAP: begin
                if (tick_cnt >= TICK_W'(ranger_cfg.gap_ticks)) begin
                    if (round_idx >= LAST_ROUND) begin
                        avg = dist_sum / SUM_W'(ROUNDS);
                        if (avg > SUM_W'(DIST_MAX)) avg = SUM_W'(DIST_MAX);
                        last_dist = avg[DIST_W-1:0];
                        // far test first, so a near limit above the far one never wins
                        if (last_dist > ranger_cfg.far_limit) last_zone = ZONE_FAR;
                        else if (last_dist > ranger_cfg.near_limit) last_zone = ZONE_MID;
                        else last_zone = ZONE_NEAR;
                        reading.done = 1'b1;
                        bursts_averaged++;
                        zone_hits[last_zone]++;
                        seq_phase = PH_IDLE;
                        tick_cnt  = '0;
                        round_idx = '0;
                    end else begin
                        round_idx = round_idx + ROUND_W'(1);
                        seq_phase = PH_TRIG;
                        tick_cnt  = TICK_W'(1);
                    end
                end else begin
                    tick_cnt = tick_cnt + TICK_W'(1);
                end
            end
            default: begin
                seq_phase = PH_IDLE;
                tick_cnt  = '0;
            end
        endcase
        reading.trigger  = (seq_phase == PH_TRIG);
        reading.busy     = (seq_phase != PH_IDLE);
        reading.distance = last_dist;
        reading.zone     = last_zone;
        ranger_readings.push_back(reading);
    endtask

    task automatic check_field(input string what, input int unsigned want, input int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s expected %0d got %0d", $time, what, want, got);
        end
    endtask

    // tick driver
    always @(posedge i_clk) begin : tick_driver
        t_tick nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            tick_live = 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                ranger_step(i_start_req, i_echo);
                tick_live = 1'b0;
            end
            if (!tick_live && echo_ticks.size() != 0
                    && $urandom_range(0, 99) >= sender_gap_pct) begin
                nxt = echo_ticks.pop_front();
                i_in_valid  <= 1'b1;
                i_start_req <= nxt.start_req;
                i_echo      <= nxt.echo;
                tick_live = 1'b1;
            end else if (!tick_live) begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // output monitor
    always @(posedge i_clk) begin : out_monitor
        t_result want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (ranger_readings.size() == 0) begin
                    mismatches++;
                    $display("%0t: output transfer with no tick pending, expected none, %s",
                             $time, "got");
                    $display("    %0b %0b %0b %0d %0d",
                             o_trigger, o_busy_res, o_done_res, o_distance, o_zone);
                end else begin
                    want = ranger_readings.pop_front();
                    check_field("trigger", want.trigger, o_trigger);
                    check_field("busy_res", want.busy, o_busy_res);
                    check_field("done_res", want.done, o_done_res);
                    check_field("distance", want.distance, o_distance);
                    check_field("zone", want.zone, o_zone);
                    readings_checked++;
                end
            end
            i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_TRIGGER_TICKS: ranger_cfg.trigger_ticks = val[TRIG_W-1:0];
            CFG_GAP_TICKS:     ranger_cfg.gap_ticks     = val[GAP_W-1:0];
            CFG_SCALE_FACTOR:  ranger_cfg.scale_factor  = val[SCALE_W-1:0];
            CFG_NEAR_LIMIT:    ranger_cfg.near_limit    = val[DIST_W-1:0];
            CFG_FAR_LIMIT:     ranger_cfg.far_limit     = val[DIST_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input int trig, input int gap, input int scale,
                                  input int near, input int far);
        logic [CFG_DAT_W-1:0] junk;
        // unused upper data bits carry noise
        junk = CFG_DAT_W'($urandom);
        write_reg(CFG_TRIGGER_TICKS, {junk[CFG_DAT_W-1:TRIG_W], TRIG_W'(trig)});
        write_reg(CFG_GAP_TICKS, GAP_W'(gap));
        write_reg(CFG_SCALE_FACTOR, {junk[CFG_DAT_W-1:SCALE_W], SCALE_W'(scale)});
        write_reg(CFG_NEAR_LIMIT, {junk[CFG_DAT_W-1:DIST_W], DIST_W'(near)});
        write_reg(CFG_FAR_LIMIT, {junk[CFG_DAT_W-1:DIST_W], DIST_W'(far)});
        settings_applied++;
    endtask

    task automatic push_tick(input logic start_req, input logic echo, input bit counted);
        t_tick tk;
        tk.start_req = start_req;
        tk.echo      = echo;
        echo_ticks.push_back(tk);
        if (counted) ticks_generated++;
    endtask

    // wait out every pending transfer, then flush any burst left running
    task automatic settle();
        forever begin
            while (echo_ticks.size() != 0 || tick_live || ranger_readings.size() != 0)
                @(posedge i_clk);
            if (seq_phase == PH_IDLE) break;
            repeat (16) push_tick(1'b0, 1'($urandom), 1'b1);
        end
        repeat (3) @(posedge i_clk);
    endtask

    task automatic push_burst(input int max_high);
        int trig_len;
        int r;
        trig_len = (ranger_cfg.trigger_ticks == '0) ? 1 : int'(ranger_cfg.trigger_ticks);
        for (r = 0; r < ROUNDS; r++) begin
            push_tick((r == 0) ? 1'b1 : 1'($urandom), 1'($urandom), 1'b1);
            repeat (trig_len) push_tick(1'($urandom), 1'($urandom), 1'b1);
            repeat ($urandom_range(0, 3)) push_tick(1'($urandom), 1'b0, 1'b1);
            repeat ($urandom_range(1, max_high)) push_tick(1'($urandom), 1'b1, 1'b1);
            push_tick(1'($urandom), 1'b0, 1'b1);
            repeat (int'(ranger_cfg.gap_ticks)) push_tick(1'($urandom), 1'($urandom), 1'b1);
        end
        push_tick(1'($urandom), 1'($urandom), 1'b1);
    endtask

    task automatic push_broken();
        push_tick(1'b1, 1'($urandom), 1'b1);
        repeat ($urandom_range(3, 30)) push_tick(1'($urandom), 1'($urandom), 1'b1);
        settle();
    endtask

    initial begin : stimulus
        int p;
        int r;
        int i;
        int max_high;
        int phase_base;
        int pick;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_start_req = 1'b0;
        i_echo      = 1'b0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        tick_live   = 1'b0;
        quiet_cycles = 0;
        sender_gap_pct = 0;
        recv_stall_pct = 0;
        ranger_reset();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // idle at reset settings, echo ignored
        push_tick(1'b0, 1'b0, 1'b1);
        push_tick(1'b0, 1'b1, 1'b1);
        settle();

        // zero trigger length, start held through the burst, late echo, middle zone
        apply_settings(0, 0, 65535, 0, 1);
        for (r = 0; r < ROUNDS; r++) begin
            push_tick(1'b1, 1'b1, 1'b1);
            push_tick(1'b1, 1'b1, 1'b1);
            if (r == 0) push_tick(1'b1, 1'b0, 1'b1);
            repeat ((r == ROUNDS - 1) ? 6 : 1) push_tick(1'b1, 1'b1, 1'b1);
            push_tick(1'b1, 1'b0, 1'b1);
        end
        push_tick(1'b1, 1'b1, 1'b1);
        push_tick(1'b0, 1'b0, 1'b1);

        for (p = 0; p < SETTING_RUNS; p++) begin
            settle();
            max_high = 12;
            case (p)
                0: begin
                    apply_settings(1, 0, 65535, 3, 8);
                    for (i = int'(CFG_FAR_LIMIT) + 1; i < (1 << CFG_IDX_W); i++)
                        write_reg(CFG_IDX_W'(i), CFG_DAT_W'($urandom));
                end
                1: begin
                    apply_settings(3, 2, 32768, 2, 6);
                    max_high = 20;
                end
                2: begin
                    apply_settings(2, 1, 65535, 10, 5);
                    max_high = 16;
                end
                3: apply_settings(24, 3, 49152, 4, 12);
                4: apply_settings(1023, 1048575, 65535, 524287, 524287);
                5: begin
                    apply_settings(1, 0, 0, 0, 0);
                    max_high = 8;
                end
                6: begin
                    apply_settings(5, 4, 27853, 20, 60);
                    max_high = 100;
                end
                7: begin
                    apply_settings(0, 1, 65535, 0, 524287);
                    max_high = 10;
                end
                default: begin
                    apply_settings($urandom_range(0, 12), $urandom_range(0, 12),
                                   $urandom_range(0, 65535), $urandom_range(0, 40),
                                   $urandom_range(0, 40));
                    max_high = 30;
                end
            endcase
            case (p % 4)
                0: begin sender_gap_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_gap_pct = 84; recv_stall_pct = 0;  end
                2: begin sender_gap_pct = 0;  recv_stall_pct = 84; end
                default: begin sender_gap_pct = 9; recv_stall_pct = 9; end
            endcase
            if (p == 4) begin
                // register extremes held only while idle
                repeat (20) push_tick(1'b0, 1'($urandom), 1'b0);
            end else begin
                phase_base = ticks_generated;
                while (ticks_generated - phase_base < PHASE_TICKS) begin
                    pick = $urandom_range(0, 9);
                    if (pick < 7) push_burst(max_high);
                    else if (pick < 9) push_broken();
                    else repeat ($urandom_range(1, 4)) push_tick(1'b0, 1'($urandom), 1'b0);
                end
            end
        end
        settle();

        $display("summary: %0d output transfers checked over %0d register settings",
                 readings_checked, settings_applied);
        $display("summary: %0d ticks generated, %0d bursts averaged, zones %0d %0d %0d",
                 ticks_generated, bursts_averaged, zone_hits[0], zone_hits[1], zone_hits[2]);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
